// ===== hdl/apts_pkg.sv =====
// ----------------------------------------------------------------------------
// apts_pkg
// Shared types and codes of the aging priority ticket scheduler.
// ----------------------------------------------------------------------------
package apts_pkg;

   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIMEOUT_LIMIT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLASS_BONUS   = 2'd1;

   localparam logic [15:0] TIMEOUT_LIMIT_RESET = 16'd30;
   localparam logic [15:0] CLASS_BONUS_RESET   = 16'd100;

   typedef enum logic [2:0] {
      REQ_TICK    = 3'd0,
      REQ_TAKE    = 3'd1,
      REQ_CALL    = 3'd2,
      REQ_CANCEL  = 3'd3,
      REQ_UPGRADE = 3'd4,
      REQ_QUERY   = 3'd5
   } req_code_type;

   typedef enum logic [1:0] {
      ST_WAIT    = 2'd0,
      ST_SERVE   = 2'd1,
      ST_TIMEOUT = 2'd2,
      ST_CANCEL  = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic        customer_class;
      logic [15:0] ticket_number;
      logic [3:0]  window_index;
   } req_item_type;

   typedef struct packed {
      logic        ok;
      logic        out_class;
      logic [15:0] out_number;
      logic [6:0]  queue_position;
      logic [6:0]  waiting_total;
      logic [3:0]  free_windows;
   } rsp_type;

   // One table entry without its take time.
   typedef struct packed {
      logic        cls;
      logic [15:0] number;
      status_type  status;
      logic [3:0]  window;
   } entry_type;

endpackage

// ===== hdl/apts_ram.sv =====
// ----------------------------------------------------------------------------
// apts_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module apts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hdl/aging_priority_ticket_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// aging_priority_ticket_scheduler_unit
// Ticket table with aging priority, timeouts and per-class numbering.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// follows on rsp_item, marked by rsp_valid for one cycle, and it cannot be
// held off. Tick and unknown requests go from IDLE straight to REPLY, which
// registers the result. Take, call, cancel, upgrade and query walk the filled
// part of the ticket RAM one entry per cycle through its single read port,
// then pass through COMMIT and REPLY; a take on a full table and a call to a
// window out of range skip the walk and go straight to REPLY. A new request
// can be accepted in the cycle its predecessor's result is on the ports.
// Configuration writes are always ready and should be issued only while the
// block is idle.
module aging_priority_ticket_scheduler_unit #(
   parameter int QUEUE_DEPTH  = 64,
   parameter int WINDOW_COUNT = 8,
   parameter int TIME_BITS    = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  apts_pkg::req_item_type                req_item,
   output logic                                  rsp_valid,
   output apts_pkg::rsp_type                     rsp_item,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [apts_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [15:0]                           csr_data
);

   localparam int AW  = $clog2(QUEUE_DEPTH);
   localparam int CNT = $clog2(QUEUE_DEPTH + 1);
   localparam int EB  = $bits(apts_pkg::entry_type);
   localparam int RW  = EB + TIME_BITS;
   localparam int CW  = (TIME_BITS > 16) ? TIME_BITS : 16;
   localparam int PW  = CW + 1;
   localparam int WB  = (WINDOW_COUNT > 1) ? $clog2(WINDOW_COUNT) : 1;
   localparam int FW  = $clog2(WINDOW_COUNT + 1);

   typedef enum logic [1:0] {IDLE, SCAN, COMMIT, REPLY} state_type;

   state_type                 state_ff;
   apts_pkg::req_item_type    req_ff;
   logic [15:0]               limit_ff, bonus_ff;
   logic [CNT-1:0]            fill_ff, wait_cnt_ff, rd_cnt_ff, rank_ff;
   logic [15:0]               next_normal_ff, next_premium_ff;
   logic [TIME_BITS-1:0]      minute_ff;
   logic [WINDOW_COUNT-1:0]   win_busy_ff;
   logic [FW-1:0]             free_ff;
   logic                      p_valid_ff;
   logic [AW-1:0]             p_idx_ff;
   logic                      found_ff;
   logic [AW-1:0]             best_idx_ff;
   logic [PW-1:0]             best_pri_ff;
   logic [RW-1:0]             best_word_ff;
   logic [CNT-1:0]            pos_ff;
   logic                      rsp_valid_ff;
   apts_pkg::rsp_type         rsp_ff;
   logic                      res_ok_ff, res_cls_ff;
   logic [15:0]               res_num_ff;

   logic                      ram_we;
   logic [AW-1:0]             ram_waddr;
   logic [RW-1:0]             ram_wdata, ram_rdata;
   logic                      issue;
   apts_pkg::entry_type       ent, ent_mod, best_ent;
   logic [TIME_BITS-1:0]      ent_time, wait_v;
   logic                      is_wait, expired, key_match;
   logic [PW-1:0]             pri;
   logic [WB-1:0]             win_sel;
   apts_pkg::rsp_type         rsp_ff_in;

   assign busy      = (state_ff != IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assign issue   = (state_ff == SCAN) && (rd_cnt_ff < fill_ff);
   assign ent     = apts_pkg::entry_type'(ram_rdata[EB-1:0]);
   assign ent_time = ram_rdata[RW-1:EB];
   assign wait_v  = TIME_BITS'(minute_ff - ent_time);
   assign is_wait = (ent.status == apts_pkg::ST_WAIT);
   assign expired = is_wait && (CW'(wait_v) > CW'(limit_ff));
   assign pri     = PW'(wait_v) + (ent.cls ? PW'(bonus_ff) : PW'(0));
   assign key_match = (ent.number == req_ff.ticket_number);
   assign win_sel = WB'(req_ff.window_index);
   assign best_ent = apts_pkg::entry_type'(best_word_ff[EB-1:0]);

   // Write port: timeout/cancel/upgrade during the walk, new or served entry at commit.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = p_idx_ff;
      ent_mod   = ent;
      ram_wdata = {ent_time, ent_mod};
      if (state_ff == SCAN && p_valid_ff) begin
         case (req_ff.req_type)
            apts_pkg::REQ_TAKE, apts_pkg::REQ_CALL: begin
               if (expired) begin
                  ram_we = 1'b1;
                  ent_mod.status = apts_pkg::ST_TIMEOUT;
               end
            end
            apts_pkg::REQ_CANCEL: begin
               if (!found_ff && key_match && is_wait && ent.cls == req_ff.customer_class) begin
                  ram_we = 1'b1;
                  ent_mod.status = apts_pkg::ST_CANCEL;
               end
            end
            apts_pkg::REQ_UPGRADE: begin
               if (!found_ff && key_match && is_wait && !ent.cls) begin
                  ram_we = 1'b1;
                  ent_mod.cls = 1'b1;
               end
            end
            default: ;
         endcase
         ram_wdata = {ent_time, ent_mod};
      end else if (state_ff == COMMIT) begin
         if (req_ff.req_type == apts_pkg::REQ_TAKE) begin
            ram_we    = 1'b1;
            ram_waddr = fill_ff[AW-1:0];
            ent_mod.cls    = req_ff.customer_class;
            ent_mod.number = req_ff.customer_class ? next_premium_ff : next_normal_ff;
            ent_mod.status = apts_pkg::ST_WAIT;
            ent_mod.window = 4'd0;
            ram_wdata = {minute_ff, ent_mod};
         end else if (req_ff.req_type == apts_pkg::REQ_CALL && found_ff) begin
            ram_we    = 1'b1;
            ram_waddr = best_idx_ff;
            ent_mod   = best_ent;
            ent_mod.status = apts_pkg::ST_SERVE;
            ent_mod.window = req_ff.window_index;
            ram_wdata = {best_word_ff[RW-1:EB], ent_mod};
         end
      end
   end

   always_comb begin
      rsp_ff_in = '0;
      rsp_ff_in.ok             = res_ok_ff;
      rsp_ff_in.out_class      = res_cls_ff;
      rsp_ff_in.out_number     = res_num_ff;
      rsp_ff_in.queue_position = 7'(pos_ff);
      rsp_ff_in.waiting_total  = 7'(wait_cnt_ff);
      rsp_ff_in.free_windows   = 4'(free_ff);
   end

   apts_ram #(.WIDTH(RW), .DEPTH(QUEUE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (rd_cnt_ff[AW-1:0]),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= IDLE;
         limit_ff        <= apts_pkg::TIMEOUT_LIMIT_RESET;
         bonus_ff        <= apts_pkg::CLASS_BONUS_RESET;
         fill_ff         <= '0;
         wait_cnt_ff     <= '0;
         next_normal_ff  <= 16'd1;
         next_premium_ff <= 16'd1;
         minute_ff       <= '0;
         win_busy_ff     <= '0;
         free_ff         <= FW'(WINDOW_COUNT);
         p_valid_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         rd_cnt_ff       <= '0;
         found_ff        <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            if (csr_index == apts_pkg::CSR_TIMEOUT_LIMIT) limit_ff <= csr_data;
            if (csr_index == apts_pkg::CSR_CLASS_BONUS)   bonus_ff <= csr_data;
         end
         case (state_ff)
            IDLE: begin
               if (start) begin
                  req_ff     <= req_item;
                  rd_cnt_ff  <= '0;
                  p_valid_ff <= 1'b0;
                  found_ff   <= 1'b0;
                  rank_ff    <= '0;
                  pos_ff     <= '0;
                  res_ok_ff  <= 1'b0;
                  res_cls_ff <= 1'b0;
                  res_num_ff <= '0;
                  state_ff   <= REPLY;
                  case (req_item.req_type)
                     apts_pkg::REQ_TICK: begin
                        minute_ff <= minute_ff + 1'b1;
                        res_ok_ff <= 1'b1;
                     end
                     apts_pkg::REQ_TAKE: begin
                        if (fill_ff < CNT'(QUEUE_DEPTH)) state_ff <= SCAN;
                     end
                     apts_pkg::REQ_CALL: begin
                        if ({28'd0, req_item.window_index} < 32'(WINDOW_COUNT))
                           state_ff <= SCAN;
                     end
                     apts_pkg::REQ_CANCEL, apts_pkg::REQ_UPGRADE,
                     apts_pkg::REQ_QUERY: state_ff <= SCAN;
                     default: ;
                  endcase
               end
            end
            SCAN: begin
               // Advance the read address; the data stage follows in the next cycle.
               if (issue) rd_cnt_ff <= rd_cnt_ff + 1'b1;
               p_valid_ff <= issue;
               p_idx_ff   <= rd_cnt_ff[AW-1:0];
               if (p_valid_ff) begin
                  case (req_ff.req_type)
                     apts_pkg::REQ_TAKE, apts_pkg::REQ_CALL: begin
                        if (expired) begin
                           wait_cnt_ff <= wait_cnt_ff - 1'b1;
                        end else if (req_ff.req_type == apts_pkg::REQ_CALL && is_wait &&
                                     (!found_ff || pri > best_pri_ff)) begin
                           found_ff     <= 1'b1;
                           best_idx_ff  <= p_idx_ff;
                           best_pri_ff  <= pri;
                           best_word_ff <= ram_rdata;
                        end
                     end
                     apts_pkg::REQ_CANCEL: begin
                        if (ram_we) begin
                           found_ff    <= 1'b1;
                           wait_cnt_ff <= wait_cnt_ff - 1'b1;
                        end
                     end
                     apts_pkg::REQ_UPGRADE: begin
                        if (ram_we) found_ff <= 1'b1;
                     end
                     apts_pkg::REQ_QUERY: begin
                        if (!found_ff) begin
                           if (is_wait) rank_ff <= rank_ff + 1'b1;
                           if (key_match && ent.cls == req_ff.customer_class) begin
                              found_ff <= 1'b1;
                              pos_ff   <= is_wait ? rank_ff + 1'b1 : '0;
                           end
                        end
                     end
                     default: ;
                  endcase
               end
               if (!issue && !p_valid_ff) state_ff <= COMMIT;
            end
            COMMIT: begin
               state_ff <= REPLY;
               case (req_ff.req_type)
                  apts_pkg::REQ_TAKE: begin
                     fill_ff     <= fill_ff + 1'b1;
                     wait_cnt_ff <= wait_cnt_ff + 1'b1;
                     res_ok_ff   <= 1'b1;
                     res_cls_ff  <= req_ff.customer_class;
                     if (req_ff.customer_class) begin
                        res_num_ff      <= next_premium_ff;
                        next_premium_ff <= next_premium_ff + 1'b1;
                     end else begin
                        res_num_ff     <= next_normal_ff;
                        next_normal_ff <= next_normal_ff + 1'b1;
                     end
                  end
                  apts_pkg::REQ_CALL: begin
                     // Serve the winner: drop it from the waiting count, mark its window.
                     if (found_ff) begin
                        wait_cnt_ff          <= wait_cnt_ff - 1'b1;
                        win_busy_ff[win_sel] <= 1'b1;
                        if (!win_busy_ff[win_sel]) free_ff <= free_ff - 1'b1;
                        res_ok_ff  <= 1'b1;
                        res_cls_ff <= best_ent.cls;
                        res_num_ff <= best_ent.number;
                     end
                  end
                  default: res_ok_ff <= found_ff;
               endcase
            end
            REPLY: begin
               state_ff     <= IDLE;
               rsp_valid_ff <= 1'b1;
               rsp_ff       <= rsp_ff_in;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
   assert property (@(posedge clock) disable iff (reset) wait_cnt_ff <= fill_ff)
      else $error("waiting count exceeds filled entries");
   assert property (@(posedge clock) disable iff (reset) fill_ff <= CNT'(QUEUE_DEPTH))
      else $error("fill count beyond table depth");
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

endmodule

// ===== bench/tb_aging_priority_ticket_scheduler_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_aging_priority_ticket_scheduler_unit
// Self-checking bench for the ticket scheduler. Requests go in through the
// start/busy handshake, and a scoreboard keeps its own copy of the ticket
// table to predict each response. Every response beat is then compared field
// by field. The run covers a directed opening, a stretch of ticks with large
// limits, and random traffic under several timeout and bonus settings.
// ----------------------------------------------------------------------------
module tb_aging_priority_ticket_scheduler_unit;

   localparam int DEPTH     = 64;
   localparam int WINDOWS   = 8;
   localparam int IDLE_LIMIT = 3000;

   class ticket_scoreboard;
      logic                 t_cls    [DEPTH];
      logic [15:0]          t_number [DEPTH];
      apts_pkg::status_type t_status [DEPTH];
      logic [15:0]          t_time   [DEPTH];
      int                   filled;
      logic [15:0]          next_norm, next_prem, minutes, limit, bonus;
      logic [7:0]           win_busy;
      apts_pkg::rsp_type    expected_q[$];
      int                   mismatches;

      function new();
         filled = 0; next_norm = 16'd1; next_prem = 16'd1; minutes = '0; win_busy = '0;
         limit = apts_pkg::TIMEOUT_LIMIT_RESET; bonus = apts_pkg::CLASS_BONUS_RESET;
         mismatches = 0;
      endfunction

      function void set_reg(logic [apts_pkg::CSR_INDEX_BITS-1:0] idx, logic [15:0] val);
         if (idx == apts_pkg::CSR_TIMEOUT_LIMIT) limit = val;
         else if (idx == apts_pkg::CSR_CLASS_BONUS) bonus = val;
      endfunction

      function logic [15:0] wait_of(int i);
         return minutes - t_time[i];
      endfunction

      function void expire();
         for (int i = 0; i < filled; i++)
            if (t_status[i] == apts_pkg::ST_WAIT && wait_of(i) > limit)
               t_status[i] = apts_pkg::ST_TIMEOUT;
      endfunction

      // Work out the response this request causes and queue it.
      function void note_request(apts_pkg::req_item_type r);
         apts_pkg::rsp_type e;
         int      best, rank, nwait;
         logic [31:0] pri, best_pri;
         e = '0;
         case (r.req_type)
            apts_pkg::REQ_TICK: begin
               minutes = minutes + 16'd1;
               e.ok = 1'b1;
            end
            apts_pkg::REQ_TAKE: if (filled < DEPTH) begin
               expire();
               t_cls[filled] = r.customer_class;
               if (r.customer_class) begin
                  t_number[filled] = next_prem; next_prem = next_prem + 16'd1;
               end else begin
                  t_number[filled] = next_norm; next_norm = next_norm + 16'd1;
               end
               t_status[filled] = apts_pkg::ST_WAIT;
               t_time[filled] = minutes;
               e.ok = 1'b1; e.out_class = r.customer_class; e.out_number = t_number[filled];
               filled++;
            end
            apts_pkg::REQ_CALL: if (r.window_index < WINDOWS) begin
               best = -1; best_pri = '0;
               expire();
               for (int i = 0; i < filled; i++)
                  if (t_status[i] == apts_pkg::ST_WAIT) begin
                     pri = 32'(wait_of(i)) + 32'(t_cls[i] ? bonus : 16'd0);
                     if (best < 0 || pri > best_pri) begin
                        best = i; best_pri = pri;
                     end
                  end
               if (best >= 0) begin
                  t_status[best] = apts_pkg::ST_SERVE;
                  win_busy[r.window_index[2:0]] = 1'b1;
                  e.ok = 1'b1; e.out_class = t_cls[best]; e.out_number = t_number[best];
               end
            end
            apts_pkg::REQ_CANCEL:
               for (int i = 0; i < filled; i++)
                  if (t_cls[i] == r.customer_class && t_number[i] == r.ticket_number &&
                      t_status[i] == apts_pkg::ST_WAIT) begin
                     t_status[i] = apts_pkg::ST_CANCEL; e.ok = 1'b1; break;
                  end
            apts_pkg::REQ_UPGRADE:
               for (int i = 0; i < filled; i++)
                  if (!t_cls[i] && t_number[i] == r.ticket_number &&
                      t_status[i] == apts_pkg::ST_WAIT) begin
                     t_cls[i] = 1'b1; e.ok = 1'b1; break;
                  end
            apts_pkg::REQ_QUERY: begin
               rank = 0;
               for (int i = 0; i < filled; i++) begin
                  if (t_status[i] == apts_pkg::ST_WAIT) rank++;
                  if (t_cls[i] == r.customer_class && t_number[i] == r.ticket_number) begin
                     e.ok = 1'b1;
                     if (t_status[i] == apts_pkg::ST_WAIT) e.queue_position = 7'(rank);
                     break;
                  end
               end
            end
            default: ;
         endcase
         nwait = 0;
         for (int i = 0; i < filled; i++) if (t_status[i] == apts_pkg::ST_WAIT) nwait++;
         e.waiting_total = 7'(nwait);
         e.free_windows = 4'(WINDOWS - $countones(win_busy));
         expected_q = {expected_q, e};
      endfunction

      function void check_response(apts_pkg::rsp_type got);
         apts_pkg::rsp_type e;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
            return;
         end
         e = expected_q.pop_front();
         if (got.ok !== e.ok || got.out_class !== e.out_class ||
             got.out_number !== e.out_number || got.queue_position !== e.queue_position ||
             got.waiting_total !== e.waiting_total || got.free_windows !== e.free_windows) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", e, got);
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   logic    busy;
   apts_pkg::req_item_type req_item = '0;
   logic    rsp_valid;
   apts_pkg::rsp_type rsp_item;
   logic    csr_valid = 0;
   logic    csr_ready;
   logic [apts_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   ticket_scoreboard sb = new();
   int  idle_pct;
   int  quiet_cycles;

   aging_priority_ticket_scheduler_unit DUT (
      .clock, .reset, .start, .busy, .req_item, .rsp_valid, .rsp_item,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_response(rsp_item);
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic send(input logic [2:0] code, input logic cls,
                       input logic [15:0] num, input logic [3:0] win);
      @(negedge clock);
      if ($urandom_range(99) < idle_pct) begin
         start = 0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_item = '{req_type: code, customer_class: cls, ticket_number: num, window_index: win};
      start = 1;
      do @(posedge clock); while (busy);
      sb.note_request(req_item);
   endtask

   task automatic drain();
      @(negedge clock);
      start = 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [apts_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [15:0] val);
      drain();
      @(negedge clock);
      csr_valid = 1; csr_index = idx; csr_data = val;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, val);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic random_items(input int count);
      int          pick;
      logic [15:0] num;
      logic [3:0]  win;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         num  = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
         win  = ($urandom_range(5) == 0) ? 4'($urandom) : 4'($urandom_range(0, 7));
         if (pick < 30)
            send(apts_pkg::REQ_TICK, 1'($urandom), 16'($urandom), 4'($urandom));
         else if (pick < 36) send(apts_pkg::REQ_TAKE, 1'($urandom), num, win);
         else if (pick < 52) send(apts_pkg::REQ_CALL, 1'($urandom), num, win);
         else if (pick < 64) send(apts_pkg::REQ_CANCEL, 1'($urandom), num, win);
         else if (pick < 75) send(apts_pkg::REQ_UPGRADE, 1'($urandom), num, win);
         else if (pick < 97) send(apts_pkg::REQ_QUERY, 1'($urandom), num, win);
         else                send(3'($urandom_range(6, 7)), 1'($urandom), num, win);
         // hold off until the block has answered everything
         if (n == count / 2) drain();
      end
   endtask

   initial begin
      idle_pct = 14;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed opening with reset settings
      send(apts_pkg::REQ_CALL, 1'b0, 16'd0, 4'd0);          // nothing waiting
      send(apts_pkg::REQ_TAKE, 1'b0, 16'd0, 4'd0);
      send(apts_pkg::REQ_TAKE, 1'b1, 16'hFFFF, 4'hF);
      send(apts_pkg::REQ_TAKE, 1'b0, 16'd0, 4'd0);
      send(apts_pkg::REQ_QUERY, 1'b0, 16'd2, 4'd0);
      send(apts_pkg::REQ_QUERY, 1'b1, 16'd1, 4'd0);
      send(apts_pkg::REQ_QUERY, 1'b1, 16'hFFFF, 4'd0);      // not found
      send(apts_pkg::REQ_UPGRADE, 1'b1, 16'd2, 4'd0);
      send(apts_pkg::REQ_UPGRADE, 1'b0, 16'd2, 4'd0);       // already premium
      send(apts_pkg::REQ_CANCEL, 1'b1, 16'd1, 4'd0);
      send(apts_pkg::REQ_CANCEL, 1'b1, 16'd1, 4'd0);        // no longer waiting
      send(apts_pkg::REQ_QUERY, 1'b1, 16'd1, 4'd0);         // found but cancelled
      send(apts_pkg::REQ_CALL, 1'b0, 16'd0, 4'd15);         // window out of range
      send(apts_pkg::REQ_CALL, 1'b0, 16'd0, 4'd8);
      send(apts_pkg::REQ_CALL, 1'b0, 16'd0, 4'd7);
      send(3'd6, 1'b1, 16'hFFFF, 4'hF);
      send(3'd7, 1'b0, 16'd0, 4'd0);
      send(apts_pkg::REQ_TAKE, 1'b1, 16'd0, 4'd0);
      for (int i = 0; i < 32; i++) send(apts_pkg::REQ_TICK, 1'b0, 16'd0, 4'd0);
      send(apts_pkg::REQ_CALL, 1'b0, 16'd0, 4'd0);          // premium ticket timed out
      random_items(600);

      write_reg(apts_pkg::CSR_TIMEOUT_LIMIT, 16'd0);
      write_reg(apts_pkg::CSR_CLASS_BONUS, 16'd0);
      idle_pct = 75;
      random_items(600);

      write_reg(apts_pkg::CSR_TIMEOUT_LIMIT, 16'hFFFF);
      write_reg(apts_pkg::CSR_CLASS_BONUS, 16'hFFFF);
      idle_pct = 0;
      send(apts_pkg::REQ_TAKE, 1'b0, 16'd0, 4'd0);
      send(apts_pkg::REQ_TAKE, 1'b1, 16'd0, 4'd0);
      for (int i = 0; i < 40; i++) send(apts_pkg::REQ_TICK, 1'b0, 16'd0, 4'd0);
      send(apts_pkg::REQ_TAKE, 1'b1, 16'd0, 4'd0);
      repeat (3) send(apts_pkg::REQ_TICK, 1'b0, 16'd0, 4'd0);
      send(apts_pkg::REQ_CALL, 1'b0, 16'd0, 4'd1);
      send(apts_pkg::REQ_CALL, 1'b0, 16'd0, 4'd2);

      write_reg(apts_pkg::CSR_TIMEOUT_LIMIT, 16'($urandom_range(5, 60)));
      write_reg(apts_pkg::CSR_CLASS_BONUS, 16'($urandom_range(0, 40)));
      random_items(600);

      drain();
      if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
